FILE: sv/i2d_pkg.sv
package i2d_pkg;

  localparam int MAG_W       = 128;
  localparam int DIGITS      = 39;
  localparam int BCD_W       = 4 * DIGITS;
  localparam int STEP_W      = $clog2(MAG_W);
  localparam int DCNT_W      = $clog2(DIGITS + 1);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [5:0] CHAR_ZERO  = 6'd48;
  localparam logic [5:0] CHAR_MINUS = 6'd45;

  typedef struct packed {
    logic signed [63:0] value_high;
    logic        [63:0] value_low;
  } in_t;

  typedef struct packed {
    logic [5:0] text_char;
    logic       is_last;
  } out_t;

  // classified request handed from front to back
  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } job_t;

endpackage

FILE: sv/i2d_front.sv
module i2d_front import i2d_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  in_t  item,
  output logic job_push,
  input  logic job_full,
  output job_t job
);

  logic             vld;
  logic [MAG_W-1:0] raw;
  logic             neg;

  assign raw = {item.value_high, item.value_low};
  assign neg = item.value_high[63];

  assign full     = vld & job_full;
  assign job_push = vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (push && !full) begin
      vld <= 1'b1;
    end else if (!job_full) begin
      vld <= 1'b0;
    end
  end

  // two's complement magnitude; -2^127 maps to the unsigned value 2^127
  always_ff @(posedge clk) begin
    if (push && !full) begin
      job.neg <= neg;
      job.mag <= neg ? (~raw + MAG_W'(1)) : raw;
    end
  end

endmodule

FILE: sv/i2d_queue.sv
module i2d_queue import i2d_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  job_t wdata,
  input  logic pop,
  output logic empty,
  output job_t rdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] cnt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt == CNT_W'(DEPTH));
  assign empty   = (cnt == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

FILE: sv/i2d_back.sv
module i2d_back import i2d_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic job_empty,
  input  job_t job,
  output logic job_pop,
  output logic empty,
  input  logic pop,
  output out_t text
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]        state;
  logic [MAG_W-1:0]  mag;
  logic [BCD_W-1:0]  bcd;
  logic [BCD_W-1:0]  bcd_adj;
  logic [STEP_W-1:0] step;
  logic [DCNT_W-1:0] dcnt;
  logic              minus;
  logic              started;
  logic              ovld;
  logic              load_ok;
  logic [3:0]        top;
  logic              last;
  logic              out_load;

  assign job_pop  = (state == ST_IDLE) & ~job_empty;
  assign empty    = ~ovld;
  assign load_ok  = ~ovld | pop;
  assign top      = bcd[BCD_W-1 -: 4];
  assign last     = (dcnt == DCNT_W'(1));
  assign out_load = (state == ST_EMIT) & load_ok & (minus | (top != 4'd0) | started | last);

  // shift-add-3: bump every digit of 5 or more before the shift
  always_comb begin
    for (int d = 0; d < DIGITS; d++) begin
      bcd_adj[4*d +: 4] = (bcd[4*d +: 4] >= 4'd5) ? bcd[4*d +: 4] + 4'd3 : bcd[4*d +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      ovld    <= 1'b0;
      minus   <= 1'b0;
      started <= 1'b0;
    end else begin
      if (out_load) begin
        ovld <= 1'b1;
      end else if (pop) begin
        ovld <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!job_empty) begin
            state <= ST_CONV;
          end
        end
        ST_CONV: begin
          if (step == STEP_W'(MAG_W - 1)) begin
            state   <= ST_EMIT;
            started <= 1'b0;
          end
        end
        ST_EMIT: begin
          if (load_ok) begin
            if (minus) begin
              minus <= 1'b0;
            end else begin
              // leading zeros are dropped, but the final digit always goes out
              if (top != 4'd0 || started || last) begin
                started <= 1'b1;
              end
              if (last) begin
                state <= ST_IDLE;
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (state == ST_IDLE && !job_empty) begin
        minus <= job.neg;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        mag  <= job.mag;
        bcd  <= '0;
        step <= '0;
        dcnt <= DCNT_W'(DIGITS);
      end
      ST_CONV: begin
        {bcd, mag} <= {bcd_adj[BCD_W-2:0], mag, 1'b0};
        step       <= step + STEP_W'(1);
      end
      ST_EMIT: begin
        if (load_ok) begin
          if (minus) begin
            text.text_char <= CHAR_MINUS;
            text.is_last   <= 1'b0;
          end else begin
            text.text_char <= CHAR_ZERO + {2'b00, top};
            text.is_last   <= last;
            bcd            <= {bcd[BCD_W-5:0], 4'd0};
            dcnt           <= dcnt - DCNT_W'(1);
          end
        end
      end
      default: begin
        step <= '0;
      end
    endcase
  end

endmodule

FILE: sv/int128_to_decimal_ascii.sv
// Signed 128-bit integer to decimal ASCII text. Each request (value_high:value_low, two's
// complement) yields its decimal text as a sequence of characters, most significant first,
// one per pop, is_last set on the final one; negative values lead with '-', zero gives '0'
// and -2^127 prints in full. A request is first picked up from the internal queue, then
// runs the shift-add-3 binary-to-BCD loop over all 128 magnitude bits, then steps through
// the 39 digit positions one at a time (leading zeros skipped but still stepped through),
// after a sign character if negative; the digit steps wait while the result is not popped.
// The front takes and classifies the next request while the back is still converting,
// holding up to QUEUE_DEPTH_P + 1 waiting requests (the queue and the front's register).
module int128_to_decimal_ascii import i2d_pkg::*; #(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  in_t  item,
  output logic empty,
  input  logic pop,
  output out_t text
);

  job_t f_job;
  job_t q_job;
  logic f_push;
  logic q_full;
  logic q_empty;
  logic q_pop;

  i2d_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .job_push (f_push),
    .job_full (q_full),
    .job      (f_job)
  );

  i2d_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .full  (q_full),
    .wdata (f_job),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_job)
  );

  i2d_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_empty (q_empty),
    .job       (q_job),
    .job_pop   (q_pop),
    .empty     (empty),
    .pop       (pop),
    .text      (text)
  );

endmodule
